@@ design/transform2d_compose_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the 2D transform compose core
// Concurrent assertion helpers that compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef TRANSFORM2D_COMPOSE_CORE_DEFINES_SVH
`define TRANSFORM2D_COMPOSE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define T2DC_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("t2dc assertion failed");
`define T2DC_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("t2dc assertion failed");
`else
`define T2DC_ASSERT_NOW(label, pre, post)
`define T2DC_ASSERT_NEXT(label, pre, post)
`endif

`endif

@@ design/t2dc_pkg.sv @@
// ----------------------------------------------------------------------------
// Package for the 2D transform compose core
// Shared fixed-point type, angle reduction constants and arithmetic helpers.
// ----------------------------------------------------------------------------
package t2dc_pkg;

  typedef logic signed [31:0] q16_t;

  localparam int unsigned ANG_LOW_BITS = 19;
  localparam int unsigned ANG_BIAS = 4140;
  localparam int unsigned MOD_DIV = 45;
  localparam int unsigned RECIP1 = 23302;
  localparam int unsigned RECIP1_SHIFT = 20;
  localparam int unsigned HALF_TURN_Q16 = 11796480;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  function automatic logic [16:0] quarter_sine(input int unsigned j, input int unsigned bits);
    logic [63:0] x;
    logic [63:0] term;
    logic signed [63:0] sum;
    x = (64'(j) * HALF_PI_Q30) >> (bits - 2);
    sum = $signed(x);
    term = x;
    for (int k = 1; k <= 7; k++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    sum = (sum + 64'sd8192) >>> 14;
    if (sum > 64'sd65536) begin
      sum = 64'sd65536;
    end
    return sum[16:0];
  endfunction

  function automatic logic signed [48:0] round_q16(input logic signed [64:0] v);
    logic signed [64:0] t;
    t = v + 65'sd32768 - $signed({64'd0, v[64]});
    return t[64:16];
  endfunction

  function automatic q16_t sat_q16(input logic signed [49:0] v);
    q16_t r;
    if (v > 50'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -50'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ design/t2dc_sincos.sv @@
// ----------------------------------------------------------------------------
// Sine and cosine of the parent angle
// Four register stages: angle modulo a full turn, table index, table lookup.
// ----------------------------------------------------------------------------
module t2dc_sincos
  import t2dc_pkg::*;
#(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic                clk_i,
  input  logic [3:0]          en_i,
  input  q16_t                angle_i,
  output logic signed [17:0]  sin_o,
  output logic signed [17:0]  cos_o
);

  localparam int unsigned B = SINE_TABLE_BITS;
  localparam int unsigned QSIZE = 1 << (B - 2);
  localparam int unsigned TW = 25 + B + 1;
  localparam int unsigned RECIP2 = ((1 << (B + 12)) + MOD_DIV - 1) / MOD_DIV;
  localparam logic [B-2:0] QIDX = (B - 1)'(QSIZE);
  localparam logic [B+6:0] RECIP2_V = (B + 7)'(RECIP2);

  logic [16:0] qtab [QSIZE+1];

  for (genvar g = 0; g <= QSIZE; g++) begin : g_tab
    assign qtab[g] = quarter_sine(g, B);
  end

  logic [13:0] hu_d, hu_q;
  logic [28:0] prod1;
  logic [7:0]  q1_q;
  logic [18:0] low_q;

  assign hu_d  = {angle_i[31], angle_i[31:ANG_LOW_BITS]} + 14'(ANG_BIAS);
  assign prod1 = 29'(hu_d) * 29'(RECIP1);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      hu_q  <= hu_d;
      q1_q  <= prod1[RECIP1_SHIFT+7:RECIP1_SHIFT];
      low_q <= angle_i[ANG_LOW_BITS-1:0];
    end
  end

  logic [13:0]   rem_full;
  logic [TW-1:0] t_full;
  logic [B+5:0]  u_q;

  assign rem_full = hu_q - 14'(q1_q) * 14'(MOD_DIV);
  assign t_full   = (TW'({rem_full[5:0], low_q}) << B) + TW'(HALF_TURN_Q16);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      u_q <= t_full[B+24:19];
    end
  end

  logic [2*B+12:0] prod2;
  logic [B-1:0]    idx_q;

  assign prod2 = (2 * B + 13)'(u_q) * (2 * B + 13)'(RECIP2_V);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      idx_q <= prod2[2*B+11:B+12];
    end
  end

  logic [1:0]   quad_s, quad_c;
  logic [B-2:0] j_fwd, j_rev;
  logic [16:0]  mag_s, mag_c;
  logic signed [17:0] sin_d, cos_d;

  assign quad_s = idx_q[B-1:B-2];
  assign quad_c = quad_s + 2'd1;
  assign j_fwd  = {1'b0, idx_q[B-3:0]};
  assign j_rev  = QIDX - j_fwd;
  assign mag_s  = quad_s[0] ? qtab[j_rev] : qtab[j_fwd];
  assign mag_c  = quad_c[0] ? qtab[j_rev] : qtab[j_fwd];
  assign sin_d  = quad_s[1] ? -$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
  assign cos_d  = quad_c[1] ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      sin_o <= sin_d;
      cos_o <= cos_d;
    end
  end

endmodule

@@ design/transform2d_compose_core.sv @@
// ----------------------------------------------------------------------------
// 2D transform compose core
// Combines a parent position, angle and scale with a child transform.
// ----------------------------------------------------------------------------
// The core takes one transfer per clock cycle unless stalled and returns each
// result through a seven-stage pipeline. Every stage has its own valid bit, so
// empty stages fill while the output is stalled and the input stalls only when
// all seven stages hold data. The stage count is set by the angle reduction and
// sine table path, which runs alongside the scale multipliers and feeds the
// rotation multipliers.
`include "transform2d_compose_core_defines.svh"

module transform2d_compose_core
  import t2dc_pkg::*;
#(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  q16_t parent_pos_x_i,
  input  q16_t parent_pos_y_i,
  input  q16_t parent_angle_i,
  input  q16_t parent_scale_x_i,
  input  q16_t parent_scale_y_i,
  input  q16_t child_pos_x_i,
  input  q16_t child_pos_y_i,
  input  q16_t child_angle_i,
  input  q16_t child_scale_x_i,
  input  q16_t child_scale_y_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output q16_t out_pos_x_o,
  output q16_t out_pos_y_o,
  output q16_t out_angle_o,
  output q16_t out_scale_x_o,
  output q16_t out_scale_y_o
);

  localparam int unsigned NSTG = 7;

  typedef struct packed {
    logic signed [47:0] x;
    logic signed [47:0] y;
    q16_t sx;
    q16_t sy;
    q16_t ppx;
    q16_t ppy;
    q16_t ang;
  } mid_t;

  typedef struct packed {
    q16_t sx;
    q16_t sy;
    q16_t ppx;
    q16_t ppy;
    q16_t ang;
  } tail_t;

  logic [NSTG-1:0] vld_q;
  logic [NSTG:0]   rdy;
  logic [NSTG-1:0] en;

  always_comb begin
    rdy[NSTG] = !out_stall_i;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
  end

  assign en         = rdy[NSTG-1:0];
  assign in_stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  logic signed [17:0] sin_w, cos_w;

  t2dc_sincos #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_sincos (
    .clk_i  (clk_i),
    .en_i   (en[3:0]),
    .angle_i(parent_angle_i),
    .sin_o  (sin_w),
    .cos_o  (cos_w)
  );

  logic signed [63:0] px_d, py_d, psx_d, psy_d;
  logic signed [63:0] px_q, py_q, psx_q, psy_q;
  logic signed [32:0] ang_sum;
  q16_t ppx1_q, ppy1_q, ang1_q;

  assign px_d    = 64'(parent_scale_x_i) * 64'(child_pos_x_i);
  assign py_d    = 64'(parent_scale_y_i) * 64'(child_pos_y_i);
  assign psx_d   = 64'(parent_scale_x_i) * 64'(child_scale_x_i);
  assign psy_d   = 64'(parent_scale_y_i) * 64'(child_scale_y_i);
  assign ang_sum = $signed({parent_angle_i[31], parent_angle_i})
                 + $signed({child_angle_i[31], child_angle_i});

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      px_q   <= px_d;
      py_q   <= py_d;
      psx_q  <= psx_d;
      psy_q  <= psy_d;
      ppx1_q <= parent_pos_x_i;
      ppy1_q <= parent_pos_y_i;
      ang1_q <= sat_q16($signed({{17{ang_sum[32]}}, ang_sum}));
    end
  end

  mid_t s2_d, s2_q, s3_q, s4_q;
  logic signed [48:0] rx_w, ry_w, rsx_w, rsy_w;

  assign rx_w  = round_q16($signed({px_q[63], px_q}));
  assign ry_w  = round_q16($signed({py_q[63], py_q}));
  assign rsx_w = round_q16($signed({psx_q[63], psx_q}));
  assign rsy_w = round_q16($signed({psy_q[63], psy_q}));

  always_comb begin
    s2_d.x   = rx_w[47:0];
    s2_d.y   = ry_w[47:0];
    s2_d.sx  = sat_q16($signed({rsx_w[48], rsx_w}));
    s2_d.sy  = sat_q16($signed({rsy_w[48], rsy_w}));
    s2_d.ppx = ppx1_q;
    s2_d.ppy = ppy1_q;
    s2_d.ang = ang1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_q <= s2_d;
    end
    if (en[2]) begin
      s3_q <= s2_q;
    end
    if (en[3]) begin
      s4_q <= s3_q;
    end
  end

  logic signed [65:0] xc_w, ys_w, xs_w, yc_w;
  logic signed [63:0] xc_q, ys_q, xs_q, yc_q;
  tail_t t5_q, t6_q;

  assign xc_w = 66'(s4_q.x) * 66'(cos_w);
  assign ys_w = 66'(s4_q.y) * 66'(sin_w);
  assign xs_w = 66'(s4_q.x) * 66'(sin_w);
  assign yc_w = 66'(s4_q.y) * 66'(cos_w);

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      xc_q     <= xc_w[63:0];
      ys_q     <= ys_w[63:0];
      xs_q     <= xs_w[63:0];
      yc_q     <= yc_w[63:0];
      t5_q.sx  <= s4_q.sx;
      t5_q.sy  <= s4_q.sy;
      t5_q.ppx <= s4_q.ppx;
      t5_q.ppy <= s4_q.ppy;
      t5_q.ang <= s4_q.ang;
    end
  end

  logic signed [64:0] dx_w, dy_w;
  logic signed [48:0] rotx_q, roty_q;

  assign dx_w = $signed({xc_q[63], xc_q}) - $signed({ys_q[63], ys_q});
  assign dy_w = $signed({xs_q[63], xs_q}) + $signed({yc_q[63], yc_q});

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      rotx_q <= round_q16(dx_w);
      roty_q <= round_q16(dy_w);
      t6_q   <= t5_q;
    end
  end

  logic signed [49:0] sumx_w, sumy_w;

  assign sumx_w = $signed({{18{t6_q.ppx[31]}}, t6_q.ppx}) + $signed({rotx_q[48], rotx_q});
  assign sumy_w = $signed({{18{t6_q.ppy[31]}}, t6_q.ppy}) + $signed({roty_q[48], roty_q});

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      out_pos_x_o   <= sat_q16(sumx_w);
      out_pos_y_o   <= sat_q16(sumy_w);
      out_angle_o   <= t6_q.ang;
      out_scale_x_o <= t6_q.sx;
      out_scale_y_o <= t6_q.sy;
    end
  end

  assign out_valid_o = vld_q[NSTG-1];

  `T2DC_ASSERT_NOW(a_stall_full, in_stall_o, (&vld_q) && out_stall_i)
  `T2DC_ASSERT_NEXT(a_enter, in_valid_i && !in_stall_o, vld_q[0])
  `T2DC_ASSERT_NEXT(a_hold_mid, vld_q[3] && !rdy[3], vld_q[3])

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the 2D transform compose core
// Streams parent and child transforms through the core under several idle
// and stall mixes, predicts each composed transform in fixed point and
// checks every result transfer field by field in order.
// ----------------------------------------------------------------------------
module testbench
  import t2dc_pkg::*;
();

  localparam int unsigned SINE_BITS = 10;
  localparam longint TURN = 64'sd23592960;
  localparam longint unsigned HALF_PI = 64'd1686629713;
  localparam int LIMIT = 200000;
  localparam int HOLD_LEN = 60;
  localparam int PHASE_ITEMS = 360;
  localparam int DRAIN = 20;
  localparam int MAX_PRINTS = 40;

  typedef struct {
    q16_t parent_pos_x;
    q16_t parent_pos_y;
    q16_t parent_angle;
    q16_t parent_scale_x;
    q16_t parent_scale_y;
    q16_t child_pos_x;
    q16_t child_pos_y;
    q16_t child_angle;
    q16_t child_scale_x;
    q16_t child_scale_y;
  } xform_in_t;

  typedef struct {
    q16_t pos_x;
    q16_t pos_y;
    q16_t angle;
    q16_t scale_x;
    q16_t scale_y;
  } xform_out_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  xform_in_t cur_item = '{default: '0};
  q16_t out_pos_x;
  q16_t out_pos_y;
  q16_t out_angle;
  q16_t out_scale_x;
  q16_t out_scale_y;

  xform_in_t xform_queue[$];
  xform_out_t composed_q[$];

  int cycles = 0;
  int errors = 0;
  int items_in = 0;
  int results_seen = 0;
  int sat_results = 0;
  bit xform_taken = 1'b0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_cnt = 0;

  transform2d_compose_core #(
    .SINE_TABLE_BITS(SINE_BITS)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .parent_pos_x_i  (cur_item.parent_pos_x),
    .parent_pos_y_i  (cur_item.parent_pos_y),
    .parent_angle_i  (cur_item.parent_angle),
    .parent_scale_x_i(cur_item.parent_scale_x),
    .parent_scale_y_i(cur_item.parent_scale_y),
    .child_pos_x_i   (cur_item.child_pos_x),
    .child_pos_y_i   (cur_item.child_pos_y),
    .child_angle_i   (cur_item.child_angle),
    .child_scale_x_i (cur_item.child_scale_x),
    .child_scale_y_i (cur_item.child_scale_y),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_pos_x_o     (out_pos_x),
    .out_pos_y_o     (out_pos_y),
    .out_angle_o     (out_angle),
    .out_scale_x_o   (out_scale_x),
    .out_scale_y_o   (out_scale_y)
  );

  // Sine over one quarter wave, evaluated as a Taylor series in Q2.30.
  function automatic longint quarter_wave(longint unsigned j);
    logic [63:0] x;
    logic [63:0] term;
    longint acc;
    int k;
    x = (j * HALF_PI) >> (SINE_BITS - 2);
    acc = longint'(x);
    term = x;
    for (k = 1; k <= 7; k++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc + 8192) >>> 14;
    if (acc > 65536) begin
      acc = 65536;
    end
    return acc;
  endfunction

  function automatic longint table_sine(longint unsigned idx);
    longint unsigned qsize;
    longint unsigned i;
    longint unsigned j;
    qsize = 64'd1 << (SINE_BITS - 2);
    i = idx & ((64'd1 << SINE_BITS) - 1);
    j = i & (qsize - 1);
    case (i >> (SINE_BITS - 2))
      0: return quarter_wave(j);
      1: return quarter_wave(qsize - j);
      2: return -quarter_wave(j);
      default: return -quarter_wave(qsize - j);
    endcase
  endfunction

  function automatic longint round_q16(longint v);
    longint unsigned mag;
    longint r;
    if (v < 0) begin
      mag = -v;
    end else begin
      mag = v;
    end
    r = longint'((mag + 64'd32768) >> 16);
    if (v < 0) begin
      return -r;
    end else begin
      return r;
    end
  endfunction

  function automatic q16_t clamp_q16(longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return q16_t'(v);
    end
  endfunction

  function automatic xform_out_t compose_xform(xform_in_t t);
    longint pa;
    longint r;
    longint sn;
    longint cs;
    longint sx;
    longint sy;
    longint unsigned idx;
    xform_out_t o;
    pa = longint'(t.parent_angle);
    r = pa % TURN;
    if (r < 0) begin
      r = r + TURN;
    end
    idx = (($unsigned(r) << SINE_BITS) + $unsigned(TURN / 2)) / $unsigned(TURN);
    sn = table_sine(idx);
    cs = table_sine(idx + (64'd1 << (SINE_BITS - 2)));
    sx = round_q16(longint'(t.parent_scale_x) * longint'(t.child_pos_x));
    sy = round_q16(longint'(t.parent_scale_y) * longint'(t.child_pos_y));
    o.pos_x = clamp_q16(longint'(t.parent_pos_x) + round_q16(sx * cs - sy * sn));
    o.pos_y = clamp_q16(longint'(t.parent_pos_y) + round_q16(sx * sn + sy * cs));
    o.angle = clamp_q16(pa + longint'(t.child_angle));
    o.scale_x = clamp_q16(round_q16(longint'(t.parent_scale_x) * longint'(t.child_scale_x)));
    o.scale_y = clamp_q16(round_q16(longint'(t.parent_scale_y) * longint'(t.child_scale_y)));
    return o;
  endfunction

  function automatic xform_in_t xf(q16_t ppx, q16_t ppy, q16_t pa, q16_t psx, q16_t psy,
                                   q16_t cpx, q16_t cpy, q16_t ca, q16_t csx, q16_t csy);
    xform_in_t t;
    t.parent_pos_x = ppx;
    t.parent_pos_y = ppy;
    t.parent_angle = pa;
    t.parent_scale_x = psx;
    t.parent_scale_y = psy;
    t.child_pos_x = cpx;
    t.child_pos_y = cpy;
    t.child_angle = ca;
    t.child_scale_x = csx;
    t.child_scale_y = csy;
    return t;
  endfunction

  function automatic q16_t rand_q16();
    case ($urandom_range(9))
      0, 1, 2, 3: return q16_t'($urandom);
      4, 5, 6: return q16_t'($urandom_range(32'h01ff_ffff)) - 32'sh0100_0000;
      7: return q16_t'($urandom_range(32'h0003_ffff)) - 32'sh0002_0000;
      8: begin
        case ($urandom_range(7))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 32'sh00010000;
          3: return -32'sh00010000;
          4: return 32'sh00008000;
          5: return 32'sd1;
          6: return -32'sd1;
          default: return 32'sd0;
        endcase
      end
      default: return q16_t'($urandom_range(6)) - 32'sd3;
    endcase
  endfunction

  // Angles favor right angles, table half-step boundaries and wide sweeps.
  function automatic q16_t rand_angle();
    case ($urandom_range(3))
      0: return rand_q16();
      1: return q16_t'((int'($urandom_range(16)) - 8) * 90 * 65536);
      2: return q16_t'((2 * int'($urandom_range(1023)) + 1) * 11520
                       + int'($urandom_range(2)) - 1
                       + (int'($urandom_range(4)) - 2) * 23592960);
      default: return q16_t'($urandom_range(32'h3fff_ffff)) - 32'sh2000_0000;
    endcase
  endfunction

  function automatic xform_in_t rand_item();
    return xf(rand_q16(), rand_q16(), rand_angle(), rand_q16(), rand_q16(),
              rand_q16(), rand_q16(), rand_angle(), rand_q16(), rand_q16());
  endfunction

  task automatic report_error(string msg);
    errors++;
    if (errors <= MAX_PRINTS) begin
      $display("ERROR: %s", msg);
    end
  endtask

  task automatic compare_field(string name, int n, q16_t got, q16_t want);
    if (got !== want) begin
      report_error($sformatf("result %0d %s: got %h expected %h", n, name, got, want));
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    while (cycles < LIMIT) @(posedge clk_i);
    $display("Timed out after %0d cycles with %0d results outstanding.",
             cycles, composed_q.size());
    $display("== FAIL ==");
    $finish;
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || xform_taken)) begin
      if (xform_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_item <= xform_queue.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_cnt == 0 && holds_done != hold_requests) begin
      hold_cnt = HOLD_LEN;
      holds_done++;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    xform_out_t want;
    cycles++;
    xform_taken = rst_ni && in_valid_i && !in_stall_o;
    if (xform_taken) begin
      composed_q.push_back(compose_xform(cur_item));
      items_in++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (composed_q.size() == 0) begin
        report_error($sformatf("result transfer with nothing pending at cycle %0d", cycles));
      end else begin
        want = composed_q.pop_front();
        compare_field("pos_x", results_seen, out_pos_x, want.pos_x);
        compare_field("pos_y", results_seen, out_pos_y, want.pos_y);
        compare_field("angle", results_seen, out_angle, want.angle);
        compare_field("scale_x", results_seen, out_scale_x, want.scale_x);
        compare_field("scale_y", results_seen, out_scale_y, want.scale_y);
        if (want.pos_x inside {32'sh7fffffff, 32'sh80000000} ||
            want.pos_y inside {32'sh7fffffff, 32'sh80000000} ||
            want.angle inside {32'sh7fffffff, 32'sh80000000} ||
            want.scale_x inside {32'sh7fffffff, 32'sh80000000} ||
            want.scale_y inside {32'sh7fffffff, 32'sh80000000}) begin
          sat_results++;
        end
        results_seen++;
      end
    end
  end

  initial begin : stimulus
    int phase;
    int n;
    q16_t one;
    q16_t qmax;
    q16_t qmin;
    one = 32'sh0001_0000;
    qmax = 32'sh7fffffff;
    qmin = 32'sh80000000;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    xform_queue.push_back(xf(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    xform_queue.push_back(xf(0, 0, 0, one, one, 32'sh0003_8000, -32'sh0002_4000,
                             q16_t'(10 * 65536), 2 * one, 32'sh0000_8000));
    xform_queue.push_back(xf(one, one, q16_t'(90 * 65536), one, one, 2 * one, 0, 0, one, one));
    xform_queue.push_back(xf(one, -one, q16_t'(180 * 65536), 2 * one, one, one, 3 * one,
                             q16_t'(45 * 65536), one, one));
    xform_queue.push_back(xf(0, 0, q16_t'(270 * 65536), one, 2 * one, 5 * one, one, 0, one, one));
    xform_queue.push_back(xf(0, 0, q16_t'(360 * 65536), one, one, 4 * one, -one, 0, one, one));
    xform_queue.push_back(xf(0, 0, q16_t'(-90 * 65536), one, one, 4 * one, -one, 0, one, one));
    xform_queue.push_back(xf(3 * one, 0, q16_t'(765 * 65536), one, one, 7 * one, 2 * one, 0,
                             one, one));
    xform_queue.push_back(xf(0, 0, 32'sd11520, one, one, 100 * one, 50 * one, 0, one, one));
    xform_queue.push_back(xf(0, 0, 32'sd11519, one, one, 100 * one, 50 * one, 0, one, one));
    xform_queue.push_back(xf(0, 0, -32'sd11520, one, one, 100 * one, 50 * one, 0, one, one));
    xform_queue.push_back(xf(0, 0, qmax, one, one, one, one, qmax, one, one));
    xform_queue.push_back(xf(0, 0, qmin, one, one, one, one, qmin, one, one));
    xform_queue.push_back(xf(qmax, qmax, qmax, qmax, qmax, qmax, qmax, qmax, qmax, qmax));
    xform_queue.push_back(xf(qmin, qmin, qmin, qmin, qmin, qmin, qmin, qmin, qmin, qmin));
    xform_queue.push_back(xf(qmax, qmax, 0, one, one, qmax, qmax, 0, one, one));
    xform_queue.push_back(xf(qmin, qmin, 0, one, one, qmin, qmin, 0, one, one));
    xform_queue.push_back(xf(0, 0, 0, 32'sd1, -32'sd1, 32'sh0000_8000, 32'sh0000_8000, 0,
                             32'sh0000_8000, 32'sh0000_8000));
    xform_queue.push_back(xf(0, 0, 0, qmax, qmax, one, one, 0, qmax, qmin));
    xform_queue.push_back(xf(qmin, qmax, q16_t'(45 * 65536), qmin, qmax, qmax, qmin,
                             q16_t'(-45 * 65536), -one, one));

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 80;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 80;
        end
        default: begin
          send_idle_pct = 31;
          recv_stall_pct = 31;
        end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        xform_queue.push_back(rand_item());
      end
      // The output holds off while the input keeps offering, so the pipeline backs up.
      if (phase == 0) begin
        hold_requests++;
      end
      while (xform_queue.size() != 0 || in_valid_i || composed_q.size() != 0) begin
        @(posedge clk_i);
      end
    end

    repeat (DRAIN) @(posedge clk_i);
    $display("Run covered %0d transfers in and %0d results out across four idle and stall mixes,",
             items_in, results_seen);
    $display("with %0d long output hold(s) and %0d results saturating at least one field.",
             holds_done, sat_results);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches found.", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
